// ----- rtl/rc4_pkg.sv -----
`default_nettype none

package rc4_pkg;

    localparam int TAB_DEPTH = 256;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    localparam logic [1:0] CMD_KEY = 2'd0;
    localparam logic [1:0] CMD_ENC = 2'd1;
    localparam logic [1:0] CMD_DEC = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_KEY_SET = 2'd1;
    localparam logic [1:0] ST_NO_KEY  = 2'd2;

    localparam logic [8:0] KEY_MAX     = 9'd256;
    localparam logic [8:0] KEY_LEN_SAT = 9'd511;

    typedef struct packed {
        logic              we;
        logic [TAB_AW-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

    typedef struct packed {
        logic              re;
        logic [TAB_AW-1:0] addr;
    } ram_rd_t;

endpackage

`default_nettype wire

// ----- rtl/rc4_req_if.sv -----
`default_nettype none

interface rc4_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] key_byte;
    logic       key_last;
    logic [7:0] data_in;

    modport source (output valid, output cmd, output key_byte, output key_last,
                    output data_in, input ready);
    modport sink (input valid, input cmd, input key_byte, input key_last,
                  input data_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/rc4_rsp_if.sv -----
`default_nettype none

interface rc4_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic [1:0] status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink (input valid, input data_out, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/rc4_stream_cipher_unit.sv -----
// Data transaction: RD_I, RD_J, WR_I, WR_J, then FIN, which registers the result
// once the output is free; a non-last key byte or error transaction goes straight to FIN.
// Last key byte: fill of 256 entries, then KS_RD, KS_J, KS_WN, KS_WJ per entry, then FIN.
// Requests are taken only in IDLE; each table memory has a single read and write port.
// rst_n (async, active low) clears state, indices, key length, key-loaded flag and
// output valid; table and key memories are not cleared and hold garbage until written.
`default_nettype none

module rc4_stream_cipher_unit
    import rc4_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rc4_req_if.sink   req,
    rc4_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_KS_RD,
        S_KS_J,
        S_KS_WN,
        S_KS_WJ,
        S_RD_I,
        S_RD_J,
        S_WR_I,
        S_WR_J,
        S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] enc_i_reg, enc_i_next, enc_j_reg, enc_j_next;
    logic [7:0] dec_i_reg, dec_i_next, dec_j_reg, dec_j_next;
    logic [8:0] key_len_reg, key_len_next;
    logic       key_loaded_reg, key_loaded_next;
    logic [8:0] len_reg, len_next;
    logic [7:0] kidx_reg, kidx_next;
    logic [7:0] wi_reg, wi_next, wj_reg, wj_next;
    logic [7:0] si_reg, si_next, sj_reg, sj_next;
    logic       sel_dec_reg, sel_dec_next;
    logic       fwd_reg, fwd_next;
    logic       use_ks_reg, use_ks_next;
    logic [7:0] res_data_reg, res_data_next;
    logic [1:0] res_status_reg, res_status_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic [1:0] out_status_reg, out_status_next;

    ram_wr_t    tab_wr, enc_wr, dec_wr, key_wr;
    ram_rd_t    tab_rd, enc_rd, dec_rd, key_rd;
    logic [7:0] enc_rdata, dec_rdata, key_rdata, tab_rdata;
    logic       sched;
    logic       accept;
    logic       out_free;
    logic [7:0] j_sum;
    logic [7:0] t_addr;
    logic [7:0] ks_byte;
    logic [8:0] key_len_inc;

    rc4_ram u_enc_ram (.clk(clk), .wr(enc_wr), .rd(enc_rd), .rdata(enc_rdata));
    rc4_ram u_dec_ram (.clk(clk), .wr(dec_wr), .rd(dec_rd), .rdata(dec_rdata));
    rc4_ram u_key_ram (.clk(clk), .wr(key_wr), .rd(key_rd), .rdata(key_rdata));

    assign req.ready    = (state_reg == S_IDLE);
    assign accept       = req.valid && req.ready;
    assign rsp.valid    = out_valid_reg;
    assign rsp.data_out = out_data_reg;
    assign rsp.status   = out_status_reg;
    assign out_free     = !out_valid_reg || rsp.ready;

    assign sched = (state_reg == S_FILL) || (state_reg == S_KS_RD) ||
                   (state_reg == S_KS_J) || (state_reg == S_KS_WN) ||
                   (state_reg == S_KS_WJ);

    assign tab_rdata   = sel_dec_reg ? dec_rdata : enc_rdata;
    assign enc_wr      = (sched || !sel_dec_reg) ? tab_wr : '0;
    assign dec_wr      = (sched || sel_dec_reg) ? tab_wr : '0;
    assign enc_rd      = sel_dec_reg ? '0 : tab_rd;
    assign dec_rd      = sel_dec_reg ? tab_rd : '0;
    assign key_len_inc = (key_len_reg == KEY_LEN_SAT) ? key_len_reg : key_len_reg + 9'd1;
    assign ks_byte     = fwd_reg ? si_reg : tab_rdata;

    always_comb
    begin
        state_next      = state_reg;
        enc_i_next      = enc_i_reg;
        enc_j_next      = enc_j_reg;
        dec_i_next      = dec_i_reg;
        dec_j_next      = dec_j_reg;
        key_len_next    = key_len_reg;
        key_loaded_next = key_loaded_reg;
        len_next        = len_reg;
        kidx_next       = kidx_reg;
        wi_next         = wi_reg;
        wj_next         = wj_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        sel_dec_next    = sel_dec_reg;
        fwd_next        = fwd_reg;
        use_ks_next     = use_ks_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        tab_wr          = '0;
        tab_rd          = '0;
        key_wr          = '0;
        key_rd          = '0;
        j_sum           = '0;
        t_addr          = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    use_ks_next     = 1'b0;
                    fwd_next        = 1'b0;
                    sel_dec_next    = (req.cmd == CMD_DEC);
                    state_next      = S_FIN;
                    if (req.cmd == CMD_KEY)
                    begin
                        if (key_loaded_reg)
                        begin
                            res_status_next = ST_KEY_SET;
                        end
                        else
                        begin
                            key_wr.we    = (key_len_reg < KEY_MAX);
                            key_wr.addr  = key_len_reg[TAB_AW-1:0];
                            key_wr.data  = req.key_byte;
                            key_len_next = key_len_inc;
                            if (req.key_last)
                            begin
                                key_loaded_next = 1'b1;
                                len_next   = (key_len_inc > KEY_MAX) ? KEY_MAX : key_len_inc;
                                wi_next    = '0;
                                state_next = S_FILL;
                            end
                        end
                    end
                    else if (req.cmd == CMD_ENC || req.cmd == CMD_DEC)
                    begin
                        if (!key_loaded_reg)
                        begin
                            res_status_next = ST_NO_KEY;
                        end
                        else
                        begin
                            res_data_next = req.data_in;
                            use_ks_next   = 1'b1;
                            wi_next    = (req.cmd == CMD_DEC) ? dec_i_reg + 8'd1
                                                              : enc_i_reg + 8'd1;
                            wj_next    = (req.cmd == CMD_DEC) ? dec_j_reg : enc_j_reg;
                            state_next = S_RD_I;
                        end
                    end
                end
            end
            S_FILL:
            begin
                tab_wr  = '{we: 1'b1, addr: wi_reg, data: wi_reg};
                wi_next = wi_reg + 8'd1;
                if (wi_reg == 8'hFF)
                begin
                    wj_next    = '0;
                    kidx_next  = '0;
                    state_next = S_KS_RD;
                end
            end
            S_KS_RD:
            begin
                tab_rd     = '{re: 1'b1, addr: wi_reg};
                key_rd     = '{re: 1'b1, addr: kidx_reg};
                state_next = S_KS_J;
            end
            S_KS_J:
            begin
                j_sum      = wj_reg + tab_rdata + key_rdata;
                si_next    = tab_rdata;
                wj_next    = j_sum;
                tab_rd     = '{re: 1'b1, addr: j_sum};
                state_next = S_KS_WN;
            end
            S_KS_WN:
            begin
                tab_wr     = '{we: 1'b1, addr: wi_reg, data: tab_rdata};
                state_next = S_KS_WJ;
            end
            S_KS_WJ:
            begin
                tab_wr    = '{we: 1'b1, addr: wj_reg, data: si_reg};
                wi_next   = wi_reg + 8'd1;
                kidx_next = ({1'b0, kidx_reg} + 9'd1 == len_reg) ? '0 : kidx_reg + 8'd1;
                state_next = (wi_reg == 8'hFF) ? S_FIN : S_KS_RD;
            end
            S_RD_I:
            begin
                tab_rd     = '{re: 1'b1, addr: wi_reg};
                state_next = S_RD_J;
            end
            S_RD_J:
            begin
                j_sum      = wj_reg + tab_rdata;
                si_next    = tab_rdata;
                wj_next    = j_sum;
                tab_rd     = '{re: 1'b1, addr: j_sum};
                state_next = S_WR_I;
            end
            S_WR_I:
            begin
                sj_next    = tab_rdata;
                tab_wr     = '{we: 1'b1, addr: wi_reg, data: tab_rdata};
                state_next = S_WR_J;
            end
            S_WR_J:
            begin
                // same-cycle read of the entry being written returns stale data
                t_addr   = si_reg + sj_reg;
                tab_wr   = '{we: 1'b1, addr: wj_reg, data: si_reg};
                tab_rd   = '{re: 1'b1, addr: t_addr};
                fwd_next = (t_addr == wj_reg);
                if (sel_dec_reg)
                begin
                    dec_i_next = wi_reg;
                    dec_j_next = wj_reg;
                end
                else
                begin
                    enc_i_next = wi_reg;
                    enc_j_next = wj_reg;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg ^ (use_ks_reg ? ks_byte : 8'd0);
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            enc_i_reg      <= '0;
            enc_j_reg      <= '0;
            dec_i_reg      <= '0;
            dec_j_reg      <= '0;
            key_len_reg    <= '0;
            key_loaded_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            enc_i_reg      <= enc_i_next;
            enc_j_reg      <= enc_j_next;
            dec_i_reg      <= dec_i_next;
            dec_j_reg      <= dec_j_next;
            key_len_reg    <= key_len_next;
            key_loaded_reg <= key_loaded_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        kidx_reg       <= kidx_next;
        wi_reg         <= wi_next;
        wj_reg         <= wj_next;
        si_reg         <= si_next;
        sj_reg         <= sj_next;
        sel_dec_reg    <= sel_dec_next;
        fwd_reg        <= fwd_next;
        use_ks_reg     <= use_ks_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

`ifndef NO_ASSERTIONS
    a_sched_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        sched |-> (enc_wr == dec_wr))
        else $error("schedule writes differ between tables");

    a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(key_loaded_reg))
        else $error("key-loaded flag cleared");

    a_sched_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_loaded_reg) |-> (state_reg == S_FILL))
        else $error("key schedule not started on last key byte");

    a_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (tab_wr.we && tab_rd.re && (tab_wr.addr == tab_rd.addr)) |-> (state_reg == S_WR_J))
        else $error("unforwarded read of entry under write");

    a_kidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KS_RD) |-> ({1'b0, kidx_reg} < len_reg))
        else $error("key index beyond key length");
`endif

endmodule

`default_nettype wire

// ----- rtl/rc4_ram.sv -----
`default_nettype none

module rc4_ram
    import rc4_pkg::*;
(
    input  wire logic    clk,
    input  wire ram_wr_t wr,
    input  wire ram_rd_t rd,
    output logic [7:0]   rdata
);

    logic [7:0] mem [TAB_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.re)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- dv/tb_rc4_stream_cipher_unit.sv -----
`default_nettype none

module tb_rc4_stream_cipher_unit;
    import rc4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int DATA_ITEMS = 750;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] key_byte;
        logic       key_last;
        logic [7:0] data_in;
    } rc4_txn_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
    } rc4_result_t;

    logic clk;
    logic rst_n;

    rc4_req_if req();
    rc4_rsp_if rsp();

    rc4_stream_cipher_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // shadow of the cipher state; index 0 is the encrypt stream, 1 the decrypt stream
    logic [7:0] sbox [2][256];
    logic [7:0] key_mem [256];
    logic [7:0] ptr_i [2];
    logic [7:0] ptr_j [2];
    logic [8:0] key_cnt;
    logic       key_ready;

    rc4_txn_t    req_backlog [$];
    rc4_result_t pending_rsp [$];
    rc4_txn_t    cur_txn;
    rc4_result_t want;
    int          burst_left = 1;
    int          gap_left = 0;
    int          mismatches = 0;
    int unsigned cycle_cnt = 0;
    logic [15:0] stall_bits = 16'hffff;

    function automatic void run_key_schedule();
        int len;
        logic [7:0] j;
        logic [7:0] t;
        len = int'(key_cnt);
        if (len > 256)
            len = 256;
        for (int n = 0; n < 256; n++)
            sbox[0][n] = n[7:0];
        j = 8'd0;
        for (int n = 0; n < 256; n++)
        begin
            j = j + sbox[0][n] + key_mem[n % len];
            t = sbox[0][n];
            sbox[0][n] = sbox[0][j];
            sbox[0][j] = t;
        end
        for (int n = 0; n < 256; n++)
            sbox[1][n] = sbox[0][n];
    endfunction

    function automatic logic [7:0] next_keystream(int s);
        logic [7:0] i;
        logic [7:0] j;
        logic [7:0] t;
        logic [7:0] k;
        i = ptr_i[s] + 8'd1;
        j = ptr_j[s] + sbox[s][i];
        t = sbox[s][i];
        sbox[s][i] = sbox[s][j];
        sbox[s][j] = t;
        ptr_i[s] = i;
        ptr_j[s] = j;
        k = sbox[s][i] + sbox[s][j];
        return sbox[s][k];
    endfunction

    function automatic rc4_result_t cipher_step(rc4_txn_t x);
        rc4_result_t r;
        r.data = 8'd0;
        r.status = ST_OK;
        case (x.cmd)
            CMD_KEY:
            begin
                if (key_ready)
                    r.status = ST_KEY_SET;
                else
                begin
                    if (key_cnt < KEY_MAX)
                        key_mem[key_cnt[7:0]] = x.key_byte;
                    if (key_cnt < KEY_LEN_SAT)
                        key_cnt = key_cnt + 9'd1;
                    if (x.key_last)
                    begin
                        run_key_schedule();
                        key_ready = 1'b1;
                    end
                end
            end
            CMD_ENC, CMD_DEC:
            begin
                if (!key_ready)
                    r.status = ST_NO_KEY;
                else
                    r.data = x.data_in ^ next_keystream((x.cmd == CMD_ENC) ? 0 : 1);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic add_txn(logic [1:0] c, logic [7:0] kb, logic kl, logic [7:0] d);
        rc4_txn_t x;
        x.cmd = c;
        x.key_byte = kb;
        x.key_last = kl;
        x.data_in = d;
        req_backlog.push_back(x);
    endtask

    task automatic add_random_txn(logic [1:0] c);
        add_txn(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)));
    endtask

    // driver: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            req.valid <= 1'b0;
        else
        begin
            if (req.valid && req.ready)
                pending_rsp.push_back(cipher_step(cur_txn));
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    cur_txn = req_backlog.pop_front();
                    req.cmd <= cur_txn.cmd;
                    req.key_byte <= cur_txn.key_byte;
                    req.key_last <= cur_txn.key_last;
                    req.data_in <= cur_txn.data_in;
                    req.valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // receiver backpressure, mode selected by cycle_cnt[10:9]
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (cycle_cnt[3:0] == 4'hf)
                stall_bits = 16'($urandom);
            case (cycle_cnt[10:9])
                2'd0: rsp.ready <= 1'b1;
                2'd1: rsp.ready <= ($urandom_range(0, 3) != 0);
                2'd2: rsp.ready <= stall_bits[cycle_cnt[3:0]];
                default: rsp.ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch($sformatf("unexpected response data %02h status %0d",
                                          rsp.data_out, rsp.status));
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.data_out !== want.data)
                    report_mismatch($sformatf("data_out %02h, want %02h",
                                              rsp.data_out, want.data));
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp.status, want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int key_len;
        int pick;
        logic [7:0] kb;

        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_KEY;
        req.key_byte = 8'd0;
        req.key_last = 1'b0;
        req.data_in = 8'd0;
        rsp.ready = 1'b0;
        key_cnt = 9'd0;
        key_ready = 1'b0;
        for (int s = 0; s < 2; s++)
        begin
            ptr_i[s] = 8'd0;
            ptr_j[s] = 8'd0;
        end

        // data and unused command before any key
        add_txn(CMD_ENC, 8'hff, 1'b1, 8'h00);
        add_txn(CMD_DEC, 8'h00, 1'b0, 8'hff);
        add_txn(CMD_NOP, 8'hff, 1'b1, 8'hff);
        add_txn(CMD_ENC, 8'h00, 1'b0, 8'hff);

        // key: short, mid, around the table size, or past the length saturation
        pick = $urandom_range(0, 3);
        case (pick)
            0: key_len = $urandom_range(1, 8);
            1: key_len = $urandom_range(9, 255);
            2: key_len = $urandom_range(256, 300);
            default: key_len = $urandom_range(512, 530);
        endcase
        for (int n = 0; n < key_len; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_random_txn(2'($urandom_range(1, 3)));
            if (n == 0)
                kb = 8'h00;
            else if (n == 1)
                kb = 8'hff;
            else
                kb = 8'($urandom_range(0, 255));
            add_txn(CMD_KEY, kb, (n == key_len - 1), 8'($urandom_range(0, 255)));
        end

        // key already set, extremes of data on both streams
        add_txn(CMD_ENC, 8'h00, 1'b0, 8'h00);
        add_txn(CMD_ENC, 8'hff, 1'b1, 8'hff);
        add_txn(CMD_DEC, 8'h00, 1'b0, 8'h00);
        add_txn(CMD_DEC, 8'hff, 1'b1, 8'hff);
        add_txn(CMD_KEY, 8'hff, 1'b1, 8'h00);
        add_txn(CMD_KEY, 8'h00, 1'b0, 8'hff);
        add_txn(CMD_NOP, 8'h00, 1'b0, 8'h00);
        add_txn(CMD_ENC, 8'h5a, 1'b0, 8'ha5);
        add_txn(CMD_DEC, 8'ha5, 1'b1, 8'h5a);

        while (req_backlog.size() < DATA_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                add_random_txn(CMD_ENC);
            else if (pick < 90)
                add_random_txn(CMD_DEC);
            else if (pick < 95)
                add_random_txn(CMD_KEY);
            else
                add_random_txn(CMD_NOP);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (req_backlog.size() != 0 || req.valid || pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
